FILE: sv/timed_priority_tx_queue_defines.svh
// Assertion macros shared by the transmit queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TIMED_PRIORITY_TX_QUEUE_DEFINES_SVH
`define TIMED_PRIORITY_TX_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpq assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpq assertion failed: next-cycle check");

`endif

FILE: sv/tpq_pkg.sv
// Types and constants of the timed priority transmit queue.
// No dependencies; used by the interfaces, the slot cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int TIME_W     = 48;
    localparam int TAG_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int POWER_W    = 6;
    localparam int UNITS_W    = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 3;
    localparam int DROPS_W    = 32;
    localparam int BACKOFF_MS = 120;
    localparam int BACKOFF_W  = 10;

    // Result codes of one item.
    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED   = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_GRANTED  = 3'd2,
        ST_DEFERRED = 3'd3,
        ST_NONE_DUE = 3'd4
    } t_status;

    // Update broadcast to the slot cells at write-back.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DEFER = 2'd2,
        OP_FREE  = 2'd3
    } t_cell_op;

    // Candidate handed from cell to cell along the chain.
    typedef struct packed {
        logic                      found;
        logic [PRIO_W-1:0]         prio;
        logic [TIME_W-1:0]         due;
        logic [TAG_W-1:0]          tag;
        logic signed [POWER_W-1:0] power;
    } t_cand;

    // Write-back command for the addressed cell.
    typedef struct packed {
        t_cell_op                  op;
        logic [PRIO_W-1:0]         prio;
        logic [TIME_W-1:0]         due;
        logic [TAG_W-1:0]          tag;
        logic signed [POWER_W-1:0] power;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: sv/tpq_if.sv
// Handshake interfaces of the transmit queue: configuration, input item and result.
// Depends on tpq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Configuration write channel carrying the carrier sense enable bit.
interface tpq_cfg_if;
    logic valid;
    logic ready;
    logic carrier_sense_enable;

    modport source (output valid, output carrier_sense_enable, input ready);
    modport sink   (input valid, input carrier_sense_enable, output ready);
endinterface

// Input item channel: one beat is one enqueue or service request.
interface tpq_in_if;
    import tpq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [TIME_W-1:0]         now_ms;
    logic [TAG_W-1:0]          packet_tag;
    logic [PRIO_W-1:0]         priority_req;
    logic [DELAY_W-1:0]        release_delay;
    logic signed [POWER_W-1:0] power_level;
    logic                      channel_busy;
    logic [UNITS_W-1:0]        backoff_units;

    modport source (output valid, output func, output now_ms, output packet_tag,
                    output priority_req, output release_delay, output power_level,
                    output channel_busy, output backoff_units, input ready);
    modport sink   (input valid, input func, input now_ms, input packet_tag,
                    input priority_req, input release_delay, input power_level,
                    input channel_busy, input backoff_units, output ready);
endinterface

// Result channel: one beat per input item.
interface tpq_out_if;
    import tpq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [SLOT_W-1:0]         slot;
    logic [TAG_W-1:0]          sent_tag;
    logic signed [POWER_W-1:0] sent_power;
    logic [DROPS_W-1:0]        full_drops;

    modport source (output valid, output status, output slot, output sent_tag,
                    output sent_power, output full_drops, input ready);
    modport sink   (input valid, input status, input slot, input sent_tag,
                    input sent_power, input full_drops, output ready);
endinterface

`default_nettype wire

FILE: sv/tpq_cell.sv
// One transmit slot of the queue: entry storage plus one stage of the selection chain.
// Depends on tpq_pkg for the candidate and command types.
`timescale 1ns / 1ps
`default_nettype none

module tpq_cell import tpq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    parameter int CELL_IDX    = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_func,
    input  logic [TIME_W-1:0]              i_now,
    input  t_cand                          i_cand,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_cand_idx,
    output t_cand                          o_cand,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_cand_idx,
    input  t_cell_cmd                      i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_cmd_idx
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic                      r_valid;
    logic [PRIO_W-1:0]         r_prio;
    logic [TIME_W-1:0]         r_due;
    logic [TAG_W-1:0]          r_tag;
    logic signed [POWER_W-1:0] r_power;
    t_cand                     r_cand;
    logic [IDX_W-1:0]          r_cand_idx;

    t_cand                     n_cand;
    logic [IDX_W-1:0]          n_cand_idx;
    logic                      eligible;
    logic                      better;
    logic                      take;
    logic                      hit;

    // A service item takes a due entry that beats the incoming candidate; an
    // enqueue item takes the first free slot. Ties keep the lower index.
    always_comb begin
        eligible = r_valid && (r_due <= i_now);
        better   = !i_cand.found || (r_prio < i_cand.prio) ||
                   ((r_prio == i_cand.prio) && (r_due < i_cand.due));
        take     = i_func ? (eligible && better) : (!r_valid && !i_cand.found);
        if (take) begin
            n_cand.found = 1'b1;
            n_cand.prio  = r_prio;
            n_cand.due   = r_due;
            n_cand.tag   = r_tag;
            n_cand.power = r_power;
            n_cand_idx   = IDX_W'(CELL_IDX);
        end else begin
            n_cand     = i_cand;
            n_cand_idx = i_cand_idx;
        end
        hit = (i_cmd_idx == IDX_W'(CELL_IDX));
    end

    // Chain stage register, handed to the next cell every cycle.
    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_cand_idx <= n_cand_idx;
    end

    // Entry storage and write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (hit) begin
            case (i_cmd.op)
                OP_WRITE: begin
                    r_valid <= 1'b1;
                    r_prio  <= i_cmd.prio;
                    r_due   <= i_cmd.due;
                    r_tag   <= i_cmd.tag;
                    r_power <= i_cmd.power;
                end
                OP_DEFER: begin
                    r_due <= i_cmd.due;
                end
                OP_FREE: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

`default_nettype wire

FILE: sv/timed_priority_tx_queue.sv
// An input beat is latched in the idle state; during the scan state the selection
// candidate passes through the chain of QUEUE_DEPTH slot cells; the write-back state then
// updates the addressed cell and loads the output register, and the block returns to idle.
// One item at a time, taken in idle; write-back waits for a free output register.
// A new input beat is taken while an earlier result still waits at the output register.
// Reset (synchronous, active low): all slots empty, drop counter zero, carrier sense off.
`timescale 1ns / 1ps
`default_nettype none

module timed_priority_tx_queue import tpq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpq_cfg_if.sink     i_cfg,
    tpq_in_if.sink      i_in,
    tpq_out_if.source   o_out
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_cs_en;
    logic [DROPS_W-1:0]        r_drops;

    // Latched input item.
    logic                      r_func;
    logic [TIME_W-1:0]         r_now;
    logic [TAG_W-1:0]          r_tag;
    logic [PRIO_W-1:0]         r_prio;
    logic [DELAY_W-1:0]        r_delay;
    logic signed [POWER_W-1:0] r_power;
    logic                      r_busy;
    logic [UNITS_W-1:0]        r_units;

    // Output register.
    logic                      r_out_valid;
    t_status                   r_status;
    logic [SLOT_W-1:0]         r_slot;
    logic [TAG_W-1:0]          r_sent_tag;
    logic signed [POWER_W-1:0] r_sent_power;
    logic [DROPS_W-1:0]        r_full_drops;

    t_cand                     w_cand [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]          w_idx  [QUEUE_DEPTH+1];
    t_cand                     last;
    t_cell_cmd                 cmd;
    logic                      wb_go;
    t_status                   res_status;
    logic [SLOT_W-1:0]         res_slot;
    logic [TAG_W-1:0]          res_tag;
    logic signed [POWER_W-1:0] res_power;
    logic                      drops_inc;
    logic [BACKOFF_W-1:0]      backoff;

    // Head of the chain: no candidate yet.
    assign w_cand[0] = '0;
    assign w_idx[0]  = '0;

    // Chain of slot cells, lowest index first.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tpq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_func     (r_func),
            .i_now      (r_now),
            .i_cand     (w_cand[g]),
            .i_cand_idx (w_idx[g]),
            .o_cand     (w_cand[g+1]),
            .o_cand_idx (w_idx[g+1]),
            .i_cmd      (cmd),
            .i_cmd_idx  (w_idx[QUEUE_DEPTH])
        );
    end

    assign wb_go = (r_state == S_WB) && (!r_out_valid || o_out.ready);

    // Result and write-back command from the candidate at the end of the chain.
    always_comb begin
        last       = w_cand[QUEUE_DEPTH];
        cmd        = '0;
        res_status = ST_NONE_DUE;
        res_slot   = '0;
        res_tag    = '0;
        res_power  = '0;
        drops_inc  = 1'b0;
        backoff    = BACKOFF_W'(r_units) * BACKOFF_W'(BACKOFF_MS);
        if (!r_func) begin
            if (last.found) begin
                res_status = ST_QUEUED;
                res_slot   = SLOT_W'(w_idx[QUEUE_DEPTH]);
                cmd.op     = OP_WRITE;
                cmd.prio   = r_prio;
                cmd.due    = r_now + TIME_W'(r_delay);
                cmd.tag    = r_tag;
                cmd.power  = r_power;
            end else begin
                res_status = ST_DROPPED;
                drops_inc  = 1'b1;
            end
        end else if (last.found) begin
            res_slot = SLOT_W'(w_idx[QUEUE_DEPTH]);
            if (r_cs_en && r_busy) begin
                res_status = ST_DEFERRED;
                cmd.op     = OP_DEFER;
                cmd.due    = r_now + TIME_W'(backoff);
            end else begin
                res_status = ST_GRANTED;
                res_tag    = last.tag;
                res_power  = last.power;
                cmd.op     = OP_FREE;
            end
        end
        if (!wb_go) begin
            cmd.op = OP_NONE;
        end
    end

    // Sequencer: accept, let the candidate run the chain, write back and present.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cs_en     <= 1'b0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cs_en <= i_cfg.carrier_sense_enable;
            end
            // The result register fills at write-back and empties on a taken beat.
            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func  <= i_in.func;
                        r_now   <= i_in.now_ms;
                        r_tag   <= i_in.packet_tag;
                        r_prio  <= i_in.priority_req;
                        r_delay <= i_in.release_delay;
                        r_power <= i_in.power_level;
                        r_busy  <= i_in.channel_busy;
                        r_units <= i_in.backoff_units;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (wb_go) begin
                        r_status     <= res_status;
                        r_slot       <= res_slot;
                        r_sent_tag   <= res_tag;
                        r_sent_power <= res_power;
                        r_full_drops <= r_drops + DROPS_W'(drops_inc);
                        r_drops      <= r_drops + DROPS_W'(drops_inc);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cfg.ready      = i_rst_n;
    assign i_in.ready       = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.slot       = r_slot;
    assign o_out.sent_tag   = r_sent_tag;
    assign o_out.sent_power = r_sent_power;
    assign o_out.full_drops = r_full_drops;

endmodule

`default_nettype wire

FILE: sv/tpq_checker.sv
// Port-level checker of the transmit queue and its bind to the top level.
// Depends on tpq_pkg and timed_priority_tx_queue_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "timed_priority_tx_queue_defines.svh"

module tpq_checker import tpq_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [STATUS_W-1:0]       i_status,
    input wire logic [SLOT_W-1:0]         i_slot,
    input wire logic [TAG_W-1:0]          i_sent_tag,
    input wire logic signed [POWER_W-1:0] i_sent_power,
    input wire logic [DROPS_W-1:0]        i_full_drops
);

    // One item at a time: the input closes right after a beat.
    `TPQ_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result beat holds.
    `TPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_slot) && $stable(i_full_drops))

    // Only a grant carries a packet handle and power.
    `TPQ_ASSERT_NOW(a_tag_grant, i_clk, i_rst_n, i_out_valid && (i_status != ST_GRANTED), (i_sent_tag == '0) && (i_sent_power == '0))

    // A drop or an empty service names no slot.
    `TPQ_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, i_out_valid && ((i_status == ST_DROPPED) || (i_status == ST_NONE_DUE)), i_slot == '0)

endmodule

bind timed_priority_tx_queue tpq_checker u_tpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_slot       (o_out.slot),
    .i_sent_tag   (o_out.sent_tag),
    .i_sent_power (o_out.sent_power),
    .i_full_drops (o_out.full_drops)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the timed priority transmit queue: a directed table, then random beats.
// Depends on tpq_pkg, the handshake interfaces in tpq_if.sv and timed_priority_tx_queue.
`timescale 1ns / 1ps

module tb_top;
    import tpq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 2 * (DEPTH + 2);
    localparam int RAND_PHASES  = 4;
    localparam int PHASE_ITEMS  = 355;

    localparam logic FN_ENQUEUE = 1'b0;
    localparam logic FN_SERVICE = 1'b1;
    localparam logic [TIME_W-1:0] T_MAX = '1;

    // One input beat.
    typedef struct packed {
        logic                      func;
        logic [TIME_W-1:0]         now;
        logic [TAG_W-1:0]          tag;
        logic [PRIO_W-1:0]         prio;
        logic [DELAY_W-1:0]        delay;
        logic signed [POWER_W-1:0] power;
        logic                      busy;
        logic [UNITS_W-1:0]        units;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_status                   status;
        logic [SLOT_W-1:0]         slot;
        logic [TAG_W-1:0]          tag;
        logic signed [POWER_W-1:0] power;
        logic [DROPS_W-1:0]        drops;
    } t_result;

    // One row of the directed table: a register write or an item, maybe with a typed result.
    typedef struct packed {
        logic    is_cfg;
        logic    cfg_val;
        t_item   item;
        logic    pinned;
        t_result pin;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    tpq_cfg_if cfg_bus ();
    tpq_in_if  item_bus ();
    tpq_out_if result_bus ();

    timed_priority_tx_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (item_bus),
        .o_out   (result_bus)
    );

    // Mirror of the slot table and the carrier sense setting.
    logic                      csense;
    logic                      q_valid [DEPTH];
    logic [PRIO_W-1:0]         q_prio  [DEPTH];
    logic [TIME_W-1:0]         q_due   [DEPTH];
    logic [TAG_W-1:0]          q_tag   [DEPTH];
    logic signed [POWER_W-1:0] q_power [DEPTH];
    logic [DROPS_W-1:0]        drops;

    t_result pending_results [$];
    t_row    script [$];
    int      items_sent;
    int      results_seen;
    int      mismatches;
    int      cycle_count;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      rx_gap;
    logic    rx_hold;
    logic    hold_trigger;
    logic    pin_on;
    t_result pin_res;
    logic [TIME_W-1:0] clock_ms;

    always #4 clk = ~clk;

    // Work out the result of one accepted beat and update the mirrored slot table.
    function automatic t_result predict_slot_table(input t_item it);
        t_result r;
        int pick;
        r = '0;
        pick = -1;
        if (it.func == FN_ENQUEUE) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (pick < 0 && !q_valid[i]) pick = i;
            end
            if (pick < 0) begin
                drops = drops + 1'b1;
                r.status = ST_DROPPED;
            end else begin
                q_valid[pick] = 1'b1;
                q_tag[pick]   = it.tag;
                q_prio[pick]  = it.prio;
                q_due[pick]   = it.now + TIME_W'(it.delay);
                q_power[pick] = it.power;
                r.status = ST_QUEUED;
                r.slot   = pick[SLOT_W-1:0];
            end
        end else begin
            // Lowest priority value, then earliest due time, then lowest index.
            for (int i = 0; i < DEPTH; i++) begin
                if (q_valid[i] && q_due[i] <= it.now) begin
                    if (pick < 0 || q_prio[i] < q_prio[pick] ||
                        (q_prio[i] == q_prio[pick] && q_due[i] < q_due[pick]))
                        pick = i;
                end
            end
            if (pick < 0) begin
                r.status = ST_NONE_DUE;
            end else if (csense && it.busy) begin
                q_due[pick] = it.now + TIME_W'(it.units) * TIME_W'(BACKOFF_MS);
                r.status = ST_DEFERRED;
                r.slot   = pick[SLOT_W-1:0];
            end else begin
                q_valid[pick] = 1'b0;
                r.status = ST_GRANTED;
                r.slot   = pick[SLOT_W-1:0];
                r.tag    = q_tag[pick];
                r.power  = q_power[pick];
            end
        end
        r.drops = drops;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Predict on every accepted input beat and compare every accepted result beat.
    always @(posedge clk) begin : queue_monitor
        t_item   beat;
        t_result want;
        if (!rst_n) begin
            csense = 1'b0;
            drops  = '0;
            for (int i = 0; i < DEPTH; i++) q_valid[i] = 1'b0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) csense = cfg_bus.carrier_sense_enable;
            if (item_bus.valid && item_bus.ready) begin
                beat.func  = item_bus.func;
                beat.now   = item_bus.now_ms;
                beat.tag   = item_bus.packet_tag;
                beat.prio  = item_bus.priority_req;
                beat.delay = item_bus.release_delay;
                beat.power = item_bus.power_level;
                beat.busy  = item_bus.channel_busy;
                beat.units = item_bus.backoff_units;
                want = predict_slot_table(beat);
                pending_results.push_back(pin_on ? pin_res : want);
            end
            if (result_bus.valid && result_bus.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected: expected nothing, got status %0d",
                             $time, result_bus.status);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, result_bus.status);
                    check_field("slot", want.slot, result_bus.slot);
                    check_field("sent_tag", want.tag, result_bus.sent_tag);
                    check_field("sent_power", want.power, result_bus.sent_power);
                    check_field("full_drops", want.drops, result_bus.full_drops);
                end
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off when it is asked for.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            rx_gap <= 0;
        end else if (rx_hold) begin
            result_bus.ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            result_bus.ready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap <= $urandom_range(0, 14);
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial begin : rx_pressure
        rx_hold = 1'b0;
        wait (hold_trigger);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** timed_priority_tx_queue: FAILED **");
            $finish;
        end
    end

    task automatic enq_row(input logic [TIME_W-1:0] now, input logic [TAG_W-1:0] tag,
                           input logic [PRIO_W-1:0] prio, input logic [DELAY_W-1:0] delay,
                           input logic signed [POWER_W-1:0] power);
        t_row r;
        r = '0;
        r.item.func  = FN_ENQUEUE;
        r.item.now   = now;
        r.item.tag   = tag;
        r.item.prio  = prio;
        r.item.delay = delay;
        r.item.power = power;
        script.push_back(r);
    endtask

    task automatic svc_row(input logic [TIME_W-1:0] now, input logic busy,
                           input logic [UNITS_W-1:0] units);
        t_row r;
        r = '0;
        r.item.func  = FN_SERVICE;
        r.item.now   = now;
        r.item.busy  = busy;
        r.item.units = units;
        script.push_back(r);
    endtask

    task automatic cfg_row(input logic v);
        t_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        script.push_back(r);
    endtask

    // Attach a typed result to the row just added.
    task automatic pin_last(input t_status st, input logic [SLOT_W-1:0] slot,
                            input logic [TAG_W-1:0] tag, input logic signed [POWER_W-1:0] power,
                            input logic [DROPS_W-1:0] n_drops);
        t_row r;
        r = script.pop_back();
        r.pinned       = 1'b1;
        r.pin.status   = st;
        r.pin.slot     = slot;
        r.pin.tag      = tag;
        r.pin.power    = power;
        r.pin.drops    = n_drops;
        script.push_back(r);
    endtask

    // Offer one beat, sometimes after a random idle burst, and wait until it is taken.
    task automatic send_item(input t_item it, input logic pinned, input t_result pin);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.func          <= it.func;
        item_bus.now_ms        <= it.now;
        item_bus.packet_tag    <= it.tag;
        item_bus.priority_req  <= it.prio;
        item_bus.release_delay <= it.delay;
        item_bus.power_level   <= it.power;
        item_bus.channel_busy  <= it.busy;
        item_bus.backoff_units <= it.units;
        pin_on  <= pinned;
        pin_res <= pin;
        do @(posedge clk); while (!item_bus.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back, then let the block settle.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (results_seen < items_sent) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_csense(input logic v);
        wait_drained();
        cfg_bus.valid                <= 1'b1;
        cfg_bus.carrier_sense_enable <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random beat on a mostly advancing clock, with rare jumps anywhere and near the wrap.
    function automatic t_item make_item(input int enq_pct);
        t_item it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll == 0) clock_ms = TIME_W'({$urandom, $urandom});
        else if (roll == 1) clock_ms = T_MAX - TIME_W'($urandom_range(0, 2000));
        else clock_ms = clock_ms + TIME_W'($urandom_range(0, 150));
        it.func  = ($urandom_range(0, 99) < enq_pct) ? FN_ENQUEUE : FN_SERVICE;
        it.now   = clock_ms;
        it.tag   = TAG_W'($urandom);
        it.prio  = ($urandom_range(0, 3) != 0) ? PRIO_W'($urandom_range(0, 3))
                                               : PRIO_W'($urandom);
        it.delay = ($urandom_range(0, 4) != 0) ? DELAY_W'($urandom_range(0, 400))
                                               : DELAY_W'($urandom);
        it.power = ($urandom_range(0, 19) < 17) ? POWER_W'($urandom_range(0, 31) - 9)
                                                : POWER_W'($urandom);
        it.busy  = 1'($urandom_range(0, 1));
        it.units = ($urandom_range(0, 9) != 0) ? UNITS_W'($urandom_range(1, 4))
                                               : UNITS_W'($urandom);
        return it;
    endfunction

    initial begin : stimulus
        t_row row;
        int   enq_pct [RAND_PHASES];
        enq_pct = '{65, 45, 75, 50};
        rst_n        = 1'b0;
        items_sent   = 0;
        hold_trigger = 1'b0;
        clock_ms     = '0;
        tx_idle_pct  = 25;
        rx_idle_pct  = 5;
        pin_on       = 1'b0;
        pin_res      = '0;
        cfg_bus.valid                = 1'b0;
        cfg_bus.carrier_sense_enable = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.func          = FN_ENQUEUE;
        item_bus.now_ms        = '0;
        item_bus.packet_tag    = '0;
        item_bus.priority_req  = '0;
        item_bus.release_delay = '0;
        item_bus.power_level   = '0;
        item_bus.channel_busy  = 1'b0;
        item_bus.backoff_units = '0;

        // Directed table; carrier sense is off after reset.
        svc_row('0, 1'b0, 3'd1);
        pin_last(ST_NONE_DUE, 3'd0, 16'h0, 6'sd0, 32'd0);
        enq_row('0, 16'hFFFF, 8'h00, 16'h0000, 6'sd22);
        pin_last(ST_QUEUED, 3'd0, 16'h0, 6'sd0, 32'd0);
        // Due time wraps past the top of the time range.
        enq_row(T_MAX, 16'h0000, 8'hFF, 16'hFFFF, -6'sd9);
        pin_last(ST_QUEUED, 3'd1, 16'h0, 6'sd0, 32'd0);
        // Power patterns outside the legal range are kept as given.
        enq_row(48'd100, 16'h1234, 8'd5, 16'd50, -6'sd32);
        enq_row(48'd100, 16'hAAAA, 8'd5, 16'd10, 6'sd31);
        enq_row(48'd100, 16'h5555, 8'd5, 16'd10, 6'sd0);
        enq_row(48'd200, 16'h0F0F, 8'h55, 16'h5555, 6'sd1);
        enq_row(48'd200, 16'hF0F0, 8'hAA, 16'hAAAA, -6'sd1);
        enq_row(48'd200, 16'h8001, 8'd1, 16'd0, -6'sd9);
        // Table full: drops count up.
        enq_row(48'd300, 16'h7777, 8'd0, 16'd0, 6'sd3);
        pin_last(ST_DROPPED, 3'd0, 16'h0, 6'sd0, 32'd1);
        enq_row(T_MAX, 16'h7778, 8'hFF, 16'hFFFF, 6'sd22);
        pin_last(ST_DROPPED, 3'd0, 16'h0, 6'sd0, 32'd2);
        // Busy channel is ignored while carrier sense is off.
        svc_row('0, 1'b1, 3'd7);
        pin_last(ST_GRANTED, 3'd0, 16'hFFFF, 6'sd22, 32'd2);
        svc_row(48'd105, 1'b0, 3'd1);
        pin_last(ST_NONE_DUE, 3'd0, 16'h0, 6'sd0, 32'd2);
        svc_row(48'd200, 1'b0, 3'd2);
        svc_row(48'd200, 1'b0, 3'd2);
        cfg_row(1'b1);
        // Deferral with zero backoff, then the earlier due time wins a priority tie.
        svc_row(48'd300, 1'b1, 3'd0);
        pin_last(ST_DEFERRED, 3'd4, 16'h0, 6'sd0, 32'd2);
        svc_row(48'd300, 1'b1, 3'd4);
        svc_row(48'd300, 1'b0, 3'd4);
        svc_row(T_MAX, 1'b1, 3'd7);
        svc_row(T_MAX, 1'b0, 3'd7);
        cfg_row(1'b0);
        svc_row(T_MAX, 1'b1, 3'd3);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k]) begin
            row = script[k];
            if (row.is_cfg) write_csense(row.cfg_val);
            else send_item(row.item, row.pinned, row.pin);
        end

        // Random phases, alternating the carrier sense setting.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_csense(ph % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 64 == 0) begin
                    tx_idle_pct = 10 * $urandom_range(0, 3);
                    rx_idle_pct = 4 * $urandom_range(0, 3);
                end
                if (ph == RAND_PHASES - 1 && n >= PHASE_ITEMS - 150) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (ph == 1 && n == 40) hold_trigger = 1'b1;
                send_item(make_item(enq_pct[ph]), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("** timed_priority_tx_queue: PASSED **");
        end else begin
            $display("** timed_priority_tx_queue: FAILED **");
        end
        $finish;
    end

endmodule
